// ===== rtl/ftrm_pkg.sv =====
// ----------------------------------------------------------------------------
// ftrm_pkg
// Shared widths, reset values and controller/datapath interface types for the
// fan tacho speed core.
// ----------------------------------------------------------------------------
package ftrm_pkg;

  localparam int NUM_W       = 24;   // rpm_numerator width
  localparam int CNT_W       = 16;   // tick counter and timeout width
  localparam int RPM_W       = 16;   // speed sample width
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 40;
  localparam int DIV_STEP_W  = $clog2(NUM_W + 1);

  localparam int RING_DEPTH_DEF = 7;

  // 60/2 * 16000000/256
  localparam logic [NUM_W-1:0] NUM_RESET     = NUM_W'(30 * (16000000 / 256));
  localparam logic [CNT_W-1:0] TIMEOUT_RESET = CNT_W'(62500);
  localparam logic [RPM_W-1:0] RPM_MAX       = '1;
  localparam logic [CNT_W-1:0] CNT_MAX       = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RPM_NUMERATOR = 1'b0,
    CFG_TIMEOUT_TICKS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic start;      // latch the word, arm the divider
    logic div_step;   // one quotient bit
    logic update;     // resolve speed, counter and ring write
    logic med_step;   // test one ring entry as median candidate
    logic load_out;   // move results into the output register
  } ftrm_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic med_found;
  } ftrm_status_t;

endpackage

// ===== rtl/fan_tacho_rpm_median_core.sv =====
// ----------------------------------------------------------------------------
// fan_tacho_rpm_median_core
// Reciprocal fan tachometer with a median filter over the last speed samples.
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   s_tdata[0] tach_edge
//   m_*      out  m_tvalid/m_tready   recent_rpm, median_rpm, sample_stored
//   cfg_*    in   cfg_we              cfg_index, cfg_wdata
//
// One tick word at a time: the next word is accepted only after the last one
// has passed through the divide, update, median search and output states. A
// tick with an edge steps the divider through the 24 quotient bits, a tick
// without an edge passes the divide state with no steps; the median search
// tests one ring entry a cycle until it finds the median.
// A finished result waits in the output register while the next word is
// taken; a second finished result holds the sequencer until the first goes.
// Synchronous reset clears the counter, last speed, ring and slot.
// ----------------------------------------------------------------------------
module fan_tacho_rpm_median_core #(
  parameter int RING_DEPTH = ftrm_pkg::RING_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ftrm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ftrm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ftrm_pkg::IN_DATA_W-1:0]    s_tdata,   // [0] tach_edge, rest zero
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ftrm_pkg::OUT_DATA_W-1:0]   m_tdata    // [15:0] recent_rpm,
                                                       // [31:16] median_rpm,
                                                       // [32] sample_stored
);

  ftrm_pkg::ftrm_cmd_t    cmd;
  ftrm_pkg::ftrm_status_t status;
  logic [ftrm_pkg::RPM_W-1:0] out_recent, out_median;
  logic                       out_stored;

  ftrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  ftrm_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .tach_edge  (s_tdata[0]),
    .cmd        (cmd),
    .status     (status),
    .out_recent (out_recent),
    .out_median (out_median),
    .out_stored (out_stored)
  );

  assign m_tdata = {7'b0, out_stored, out_median, out_recent};

endmodule

// ===== rtl/ftrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ftrm_ctrl
// Sequencer for one tick: divide, update, median search, output load.
// ----------------------------------------------------------------------------
module ftrm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output ftrm_pkg::ftrm_cmd_t   cmd,
  input  ftrm_pkg::ftrm_status_t status
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_MED  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign out_free = !out_valid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_busy) begin
          cmd.div_step = 1'b1;
        end else begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_next = ST_MED;
      end
      ST_MED: begin
        cmd.med_step = 1'b1;
        if (status.med_found) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/ftrm_dp.sv =====
// ----------------------------------------------------------------------------
// ftrm_dp
// Datapath: config registers, tick counter, bit-serial divider, sample ring,
// median search by rank count and the output register.
// ----------------------------------------------------------------------------
module ftrm_dp #(
  parameter int RING_DEPTH = ftrm_pkg::RING_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ftrm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ftrm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              tach_edge,
  input  ftrm_pkg::ftrm_cmd_t               cmd,
  output ftrm_pkg::ftrm_status_t            status,
  output logic [ftrm_pkg::RPM_W-1:0]        out_recent,
  output logic [ftrm_pkg::RPM_W-1:0]        out_median,
  output logic                              out_stored
);

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int RANK_W = $clog2(RING_DEPTH + 1);
  localparam int RANK   = RING_DEPTH / 2;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_DEPTH - 1);

  logic [ftrm_pkg::NUM_W-1:0]      rpm_numerator;
  logic [ftrm_pkg::CNT_W-1:0]      timeout_ticks;
  logic [ftrm_pkg::CNT_W-1:0]      tick_count, tick_count_next;
  logic [ftrm_pkg::RPM_W-1:0]      last_speed, last_speed_next;
  logic [ftrm_pkg::RPM_W-1:0]      ring [RING_DEPTH];
  logic [IDX_W-1:0]                write_slot;
  logic                            edge_q;
  logic                            stored_q, stored_next;
  logic                            store_en;

  logic [ftrm_pkg::NUM_W-1:0]      quo;
  logic [ftrm_pkg::CNT_W-1:0]      rem;
  logic [ftrm_pkg::DIV_STEP_W-1:0] div_cnt;
  logic [ftrm_pkg::CNT_W:0]        shifted;
  logic                            fits;

  logic [IDX_W-1:0]                med_idx;
  logic [ftrm_pkg::RPM_W-1:0]      cand;
  logic [RANK_W-1:0]               below, not_above;
  logic [ftrm_pkg::RPM_W-1:0]      median_q;

  logic [ftrm_pkg::CNT_W-1:0]      cnt_inc;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      rpm_numerator <= ftrm_pkg::NUM_RESET;
      timeout_ticks <= ftrm_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ftrm_pkg::CFG_RPM_NUMERATOR: rpm_numerator <= cfg_wdata;
        ftrm_pkg::CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_wdata[ftrm_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // restoring divider, one quotient bit a cycle, divisor is the held count
  assign shifted = {rem, quo[ftrm_pkg::NUM_W-1]};
  assign fits    = (shifted >= {1'b0, tick_count});

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      edge_q  <= tach_edge;
      quo     <= rpm_numerator;
      rem     <= '0;
      div_cnt <= tach_edge ? ftrm_pkg::DIV_STEP_W'(ftrm_pkg::NUM_W) : '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - 1'b1;
      if (fits) begin
        rem <= ftrm_pkg::CNT_W'(shifted - {1'b0, tick_count});
        quo <= {quo[ftrm_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[ftrm_pkg::CNT_W-1:0];
        quo <= {quo[ftrm_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  assign status.div_busy = (div_cnt != '0);

  // speed and counter update
  assign cnt_inc = (tick_count == ftrm_pkg::CNT_MAX) ? tick_count : tick_count + 1'b1;

  always_comb begin
    tick_count_next = tick_count;
    last_speed_next = last_speed;
    store_en        = 1'b0;
    stored_next     = 1'b0;
    if (edge_q) begin
      store_en        = 1'b1;
      stored_next     = 1'b1;
      tick_count_next = '0;
      if (tick_count == '0 || quo[ftrm_pkg::NUM_W-1:ftrm_pkg::RPM_W] != '0) begin
        last_speed_next = ftrm_pkg::RPM_MAX;
      end else begin
        last_speed_next = quo[ftrm_pkg::RPM_W-1:0];
      end
    end else if (cnt_inc >= timeout_ticks) begin
      store_en        = 1'b1;
      stored_next     = 1'b1;
      tick_count_next = '0;
      last_speed_next = '0;
    end else begin
      tick_count_next = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      last_speed <= '0;
      write_slot <= '0;
      for (int i = 0; i < RING_DEPTH; i++) ring[i] <= '0;
    end else if (cmd.update) begin
      tick_count <= tick_count_next;
      last_speed <= last_speed_next;
      if (store_en) begin
        ring[write_slot] <= last_speed_next;
        write_slot       <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) stored_q <= stored_next;
  end

  // median: the first entry whose rank window holds the middle rank
  always_comb begin
    cand      = ring[med_idx];
    below     = '0;
    not_above = '0;
    for (int j = 0; j < RING_DEPTH; j++) begin
      below     = below + RANK_W'(ring[j] < cand);
      not_above = not_above + RANK_W'(ring[j] <= cand);
    end
  end

  assign status.med_found = (below <= RANK_W'(RANK)) && (RANK_W'(RANK) < not_above);

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      med_idx <= '0;
    end else if (cmd.med_step) begin
      med_idx <= med_idx + 1'b1;
      if (status.med_found) median_q <= cand;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_recent <= last_speed;
      out_median <= median_q;
      out_stored <= stored_q;
    end
  end

endmodule

// ===== rtl/ftrm_checker.sv =====
// ----------------------------------------------------------------------------
// ftrm_checker
// Port-level checks on the fan tacho core, bound to the top level.
// ----------------------------------------------------------------------------
module ftrm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ftrm_pkg::OUT_DATA_W-1:0] m_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result word changed while stalled");

  // one tick word in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again right after a word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind fan_tacho_rpm_median_core ftrm_checker u_ftrm_checker (.*);

// ===== dv/fan_tacho_rpm_median_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fan_tacho_rpm_median_core_tb
// Streams tick words with and without tacho edges into the speed core under
// a series of numerator and timeout settings. A built-in tachometer
// predictor tracks the tick count, the speed ring and its median. Every
// result word is checked field by field against it. Both stream sides idle
// in random bursts, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module fan_tacho_rpm_median_core_tb;

  localparam int RING_N         = ftrm_pkg::RING_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 40;
  localparam int NUM_PHASES     = 12;

  typedef struct packed {
    logic [ftrm_pkg::RPM_W-1:0] recent;
    logic [ftrm_pkg::RPM_W-1:0] median;
    logic                       stored;
  } rpm_report_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [ftrm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ftrm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [ftrm_pkg::IN_DATA_W-1:0]  s_tdata = '0;   // [0] tach_edge, rest zero
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [ftrm_pkg::OUT_DATA_W-1:0] m_tdata;        // [15:0] recent_rpm,
                                                   // [31:16] median_rpm,
                                                   // [32] sample_stored

  fan_tacho_rpm_median_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Tachometer predictor state and its copy of the registers
  logic [ftrm_pkg::NUM_W-1:0] model_num = ftrm_pkg::NUM_RESET;
  logic [ftrm_pkg::CNT_W-1:0] model_tmo = ftrm_pkg::TIMEOUT_RESET;
  logic [ftrm_pkg::CNT_W-1:0] tach_ticks = '0;
  logic [ftrm_pkg::RPM_W-1:0] rpm_last = '0;
  logic [ftrm_pkg::RPM_W-1:0] rpm_ring [RING_N];
  int                         ring_wr = 0;

  bit          tick_q [$];
  rpm_report_t rpm_expect_q [$];
  rpm_report_t want;

  int  n_pushed = 0;
  int  n_acc = 0;
  int  n_rsp = 0;
  int  n_err = 0;
  int  n_stores = 0;
  int  n_timeouts = 0;
  int  n_sat = 0;
  int  src_gap = 0;
  int  sink_hold = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  bit  long_hold_done = 1'b0;

  initial begin
    for (int i = 0; i < RING_N; i++) rpm_ring[i] = '0;
  end

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void ring_push(input logic [ftrm_pkg::RPM_W-1:0] spd);
    rpm_last = spd;
    rpm_ring[ring_wr] = spd;
    ring_wr = (ring_wr + 1 >= RING_N) ? 0 : ring_wr + 1;
    n_stores++;
  endfunction

  // Advance the predictor by one tick word and queue the expected result
  task automatic tach_advance(input bit tach_edge);
    rpm_report_t                rpt;
    logic [31:0]                quo;
    logic [ftrm_pkg::RPM_W-1:0] spd;
    logic [ftrm_pkg::RPM_W-1:0] srt [RING_N];
    logic [ftrm_pkg::RPM_W-1:0] tmp;
    rpt.stored = 1'b0;
    if (tach_edge) begin
      if (tach_ticks == '0) begin
        spd = ftrm_pkg::RPM_MAX;
      end else begin
        quo = 32'(model_num) / 32'(tach_ticks);
        if (quo > 32'(ftrm_pkg::RPM_MAX)) begin
          spd = ftrm_pkg::RPM_MAX;
          n_sat++;
        end else begin
          spd = quo[ftrm_pkg::RPM_W-1:0];
        end
      end
      ring_push(spd);
      tach_ticks = '0;
      rpt.stored = 1'b1;
    end else begin
      if (tach_ticks != ftrm_pkg::CNT_MAX) tach_ticks = tach_ticks + 1'b1;
      if (tach_ticks >= model_tmo) begin
        ring_push('0);
        tach_ticks = '0;
        rpt.stored = 1'b1;
        n_timeouts++;
      end
    end
    // median: sort a copy, the ring itself keeps write order
    for (int i = 0; i < RING_N; i++) srt[i] = rpm_ring[i];
    for (int i = 0; i < RING_N - 1; i++) begin
      for (int j = 0; j < RING_N - 1 - i; j++) begin
        if (srt[j] > srt[j+1]) begin
          tmp = srt[j];
          srt[j] = srt[j+1];
          srt[j+1] = tmp;
        end
      end
    end
    rpt.recent = rpm_last;
    rpt.median = srt[RING_N/2];
    rpm_expect_q.push_back(rpt);
  endtask

  // Tick word driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        tach_advance(s_tdata[0]);
        n_acc++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (tick_q.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
          src_gap <= $urandom_range(0, 9);
          s_tvalid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          s_tdata <= {{(ftrm_pkg::IN_DATA_W-1){1'b0}}, tick_q.pop_front()};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_rsp++;
        if (rpm_expect_q.size() == 0) begin
          $error("result word with nothing expected: %h", m_tdata);
          n_err++;
        end else begin
          want = rpm_expect_q.pop_front();
          if (m_tdata[15:0] !== want.recent) begin
            $error("recent_rpm expected %0d actual %0d", want.recent, m_tdata[15:0]);
            n_err++;
          end
          if (m_tdata[31:16] !== want.median) begin
            $error("median_rpm expected %0d actual %0d", want.median, m_tdata[31:16]);
            n_err++;
          end
          if (m_tdata[32] !== want.stored) begin
            $error("sample_stored expected %0d actual %0d", want.stored, m_tdata[32]);
            n_err++;
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold <= sink_hold - 1;
        m_tready <= 1'b0;
      end else if (!long_hold_done && n_rsp >= 500 && tick_q.size() > 8) begin
        // long back-pressure so the core fills up and stalls its input
        long_hold_done <= 1'b1;
        sink_hold <= 300;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        sink_hold <= $urandom_range(0, 9);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_tick(input bit tach_edge);
    tick_q.push_back(tach_edge);
    n_pushed++;
  endtask

  task automatic wait_drained();
    while (!(n_acc == n_pushed && rpm_expect_q.size() == 0)) @(negedge clk);
  endtask

  task automatic write_reg(input ftrm_pkg::cfg_idx_t idx,
                           input logic [ftrm_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == ftrm_pkg::CFG_RPM_NUMERATOR) model_num = val[ftrm_pkg::NUM_W-1:0];
    else model_tmo = val[ftrm_pkg::CNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drain, let the core settle, then load both registers
  task automatic set_rates(input logic [ftrm_pkg::NUM_W-1:0] num,
                           input logic [ftrm_pkg::CNT_W-1:0] tmo);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(ftrm_pkg::CFG_RPM_NUMERATOR, num);
    write_reg(ftrm_pkg::CFG_TIMEOUT_TICKS, ftrm_pkg::CFG_DATA_W'(tmo));
  endtask

  initial begin
    logic [ftrm_pkg::NUM_W-1:0] num;
    logic [ftrm_pkg::CNT_W-1:0] tmo;
    int                         lim;
    int                         gap;
    int                         n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset values: edge on zero count, then a saturated quotient
    push_tick(1); push_tick(0); push_tick(1);

    // small numerator, short timeout: plain quotients and a timeout
    set_rates(24'd1000, 16'd4);
    push_tick(0); push_tick(1);
    push_tick(0); push_tick(0); push_tick(1);
    push_tick(0); push_tick(0); push_tick(0); push_tick(0);
    push_tick(0); push_tick(1); push_tick(1);

    // zero numerator: nonzero count gives 0, zero count still gives max
    set_rates(24'd0, 16'd3);
    push_tick(0); push_tick(1); push_tick(1);

    // zero timeout: every tick without an edge stores 0
    set_rates(24'd1, 16'd0);
    push_tick(0); push_tick(0); push_tick(1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin num = '1; tmo = '1; end
        1: begin num = 24'd1; tmo = 16'd1; end
        2: begin num = '0; tmo = '0; end
        default: begin
          case ($urandom_range(0, 3))
            0: num = ftrm_pkg::NUM_W'($urandom_range(1, 65535));
            1: num = ftrm_pkg::NUM_W'($urandom_range(65536, 4000000));
            2: num = ftrm_pkg::NUM_W'($urandom());
            default: num = ftrm_pkg::NUM_RESET;
          endcase
          if ($urandom_range(0, 4) == 0) tmo = ftrm_pkg::CNT_W'($urandom_range(301, 65535));
          else tmo = ftrm_pkg::CNT_W'($urandom_range(1, 300));
        end
      endcase
      set_rates(num, tmo);
      if (p >= NUM_PHASES - 2) quiet = 1'b1;
      lim = (int'(tmo) > 300) ? 300 : int'(tmo) + int'(tmo) / 4 + 1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        gap = $urandom_range(0, lim);
        if ($urandom_range(0, 9) == 0) begin
          // noise: edges at random within the stretch
          repeat (gap) push_tick(1'($urandom_range(0, 1)));
        end else begin
          repeat (gap) push_tick(0);
        end
        push_tick(1);
        n += gap + 1;
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (rpm_expect_q.size() != 0) begin
      $error("%0d expected result words never arrived", rpm_expect_q.size());
      n_err++;
    end
    $display("Run covered %0d tick words and %0d result words over %0d register settings.",
             n_acc, n_rsp, NUM_PHASES + 3);
    $display("Samples stored: %0d, timeouts: %0d, saturated quotients: %0d, errors: %0d.",
             n_stores, n_timeouts, n_sat, n_err);
    if (n_err == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ftrm_pkg.sv
rtl/ftrm_ctrl.sv
rtl/ftrm_dp.sv
rtl/fan_tacho_rpm_median_core.sv
rtl/ftrm_checker.sv
dv/fan_tacho_rpm_median_core_tb.sv
